/* src/mlbp_pkg.sv */
// Shared types and constants of the multi-LED blink and pulse engine.
// Used by mlbp_state_ram and multi_led_blink_pulse_engine_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlbp_pkg;

  // Default LED count handed to the top level.
  localparam int NUM_LEDS_DEF = 8;

  localparam int TIME_W  = 16;
  localparam int CYCLE_W = 8;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_ON     = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_TOGGLE = 3'd3,
    ACT_BLINK  = 3'd4,
    ACT_SHORT  = 3'd5,
    ACT_LONG   = 3'd6,
    ACT_NONE   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_BLINK_ON  = 3'd1,
    PH_BLINK_OFF = 3'd2,
    PH_SHORT_ON  = 3'd3,
    PH_SHORT_OFF = 3'd4,
    PH_LONG_ON   = 3'd5,
    PH_LONG_OFF  = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    CFG_SHORT_ON   = 3'd0,
    CFG_SHORT_OFF  = 3'd1,
    CFG_LONG_ON    = 3'd2,
    CFG_LONG_OFF   = 3'd3,
    CFG_BLINK_ON   = 3'd4,
    CFG_BLINK_OFF  = 3'd5,
    CFG_CYCLES     = 3'd6,
    CFG_UNUSED     = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DONE
  } seq_state_t;

  // One LED's pattern state as kept in the state memory.
  typedef struct packed {
    phase_t               phase;
    logic [TIME_W-1:0]    timer;
    logic [CYCLE_W-1:0]   cycles;
    logic                 restart;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{phase: PH_IDLE, timer: '0, cycles: '0, restart: 1'b0};

  localparam logic [TIME_W-1:0]  RST_SHORT_ON  = 16'd100;
  localparam logic [TIME_W-1:0]  RST_SHORT_OFF = 16'd900;
  localparam logic [TIME_W-1:0]  RST_LONG_ON   = 16'd500;
  localparam logic [TIME_W-1:0]  RST_LONG_OFF  = 16'd500;
  localparam logic [TIME_W-1:0]  RST_BLINK_ON  = 16'd250;
  localparam logic [TIME_W-1:0]  RST_BLINK_OFF = 16'd250;
  localparam logic [CYCLE_W-1:0] RST_CYCLES    = 8'd3;

endpackage

`default_nettype wire

/* src/mlbp_state_ram.sv */
// Per-LED pattern state memory: one write port, one registered read port.
// Depends on mlbp_pkg for entry_t and the reset entry value.
`timescale 1ns / 1ps
`default_nettype none

module mlbp_state_ram #(
  parameter int NUM_LEDS = mlbp_pkg::NUM_LEDS_DEF,
  parameter int IDX_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [IDX_W-1:0]    rd_addr,
  output mlbp_pkg::entry_t         rd_entry,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire mlbp_pkg::entry_t    wr_entry
);

  mlbp_pkg::entry_t mem [NUM_LEDS];
  mlbp_pkg::entry_t rd_q;
  logic [NUM_LEDS-1:0] written;
  logic                rd_written;

  // Storage itself has no reset; an entry never written reads as the reset entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_entry = rd_written ? rd_q : mlbp_pkg::ENTRY_RESET;

endmodule

`default_nettype wire

/* src/multi_led_blink_pulse_engine_top.sv */
// Multi-LED blink and pulse pattern engine, top level.
// Result path: a command's result beat passes through the S_DONE state, which holds
// while an earlier beat waits, and then the result register; a tick first sweeps every LED.
// Flow: one item at a time; a tick occupies the block for its whole sweep, because
// the sweep reads one LED per cycle from the single state memory read port.
// Reset (synchronous, active high) restores the register defaults, darkens every LED
// and marks every state memory entry as idle.
`timescale 1ns / 1ps
`default_nettype none

module multi_led_blink_pulse_engine_top #(
  parameter int NUM_LEDS = mlbp_pkg::NUM_LEDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command and tick channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [2:0]  led_select,
  input  wire logic        auto_restart,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       led_bits,
  output logic [7:0]       done_bits,
  // Register write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CNT_W = $clog2(NUM_LEDS + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_LEDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_LEDS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken. The host is to write only while
  // the engine is idle so no item sees a register change midway; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [15:0] short_on_ms, short_off_ms, long_on_ms, long_off_ms;
  logic [15:0] blink_on_ms, blink_off_ms;
  logic [7:0]  pattern_cycles;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_on_ms    <= mlbp_pkg::RST_SHORT_ON;
      short_off_ms   <= mlbp_pkg::RST_SHORT_OFF;
      long_on_ms     <= mlbp_pkg::RST_LONG_ON;
      long_off_ms    <= mlbp_pkg::RST_LONG_OFF;
      blink_on_ms    <= mlbp_pkg::RST_BLINK_ON;
      blink_off_ms   <= mlbp_pkg::RST_BLINK_OFF;
      pattern_cycles <= mlbp_pkg::RST_CYCLES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mlbp_pkg::cfg_index_t'(cfg_index))
        mlbp_pkg::CFG_SHORT_ON:  short_on_ms    <= cfg_data;
        mlbp_pkg::CFG_SHORT_OFF: short_off_ms   <= cfg_data;
        mlbp_pkg::CFG_LONG_ON:   long_on_ms     <= cfg_data;
        mlbp_pkg::CFG_LONG_OFF:  long_off_ms    <= cfg_data;
        mlbp_pkg::CFG_BLINK_ON:  blink_on_ms    <= cfg_data;
        mlbp_pkg::CFG_BLINK_OFF: blink_off_ms   <= cfg_data;
        mlbp_pkg::CFG_CYCLES:    pattern_cycles <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. A command is applied in the cycle it is accepted. A tick sweeps
  // the state memory: the read of LED i+1 overlaps the write-back of LED i, so
  // the two ports never touch the same entry in one cycle and no forwarding
  // is needed. The result beat is built from the drive and done flops once
  // the item's last update has landed.
  // ---------------------------------------------------------------------------
  mlbp_pkg::seq_state_t state, state_next;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic             wb_valid;
  logic [IDX_W-1:0] wb_idx;

  logic             in_fire;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             load_out;

  mlbp_pkg::action_t act;
  logic [IDX_W-1:0]  cmd_idx;
  logic              cmd_hit;

  assign in_fire = in_valid && in_ready;
  assign act     = mlbp_pkg::action_t'(action);
  assign cmd_idx = IDX_W'(led_select);
  // A command naming an LED at or beyond NUM_LEDS is dropped.
  assign cmd_hit = ({29'd0, led_select} < 32'(NUM_LEDS));
  assign rd_addr = rd_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mlbp_pkg::S_IDLE;
      rd_cnt   <= '0;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_cnt   <= rd_cnt_next;
      wb_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      wb_idx <= rd_addr;
    end
  end

  always_comb begin
    state_next  = state;
    rd_cnt_next = rd_cnt;
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      mlbp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_cnt_next = '0;
          state_next  = (act == mlbp_pkg::ACT_TICK) ? mlbp_pkg::S_TICK : mlbp_pkg::S_DONE;
        end
      end
      mlbp_pkg::S_TICK: begin
        if (rd_cnt != CNT_END) begin
          rd_en       = 1'b1;
          rd_cnt_next = rd_cnt + 1'b1;
        end
        if (wb_valid && (wb_idx == IDX_LAST)) begin
          state_next = mlbp_pkg::S_DONE;
        end
      end
      mlbp_pkg::S_DONE: begin
        // Hold here while the previous result beat still waits downstream.
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = mlbp_pkg::S_IDLE;
        end
      end
      default: state_next = mlbp_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pattern state memory.
  // ---------------------------------------------------------------------------
  mlbp_pkg::entry_t rd_entry, wr_entry, start_entry, wb_entry;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             cmd_start;

  mlbp_state_ram #(
    .NUM_LEDS (NUM_LEDS),
    .IDX_W    (IDX_W)
  ) u_state_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  // Starting a pattern loads the on phase, its time and a fresh cycle count.
  always_comb begin
    start_entry         = mlbp_pkg::ENTRY_RESET;
    start_entry.cycles  = pattern_cycles;
    start_entry.restart = auto_restart;
    cmd_start           = 1'b0;
    case (act)
      mlbp_pkg::ACT_BLINK: begin
        cmd_start         = 1'b1;
        start_entry.phase = mlbp_pkg::PH_BLINK_ON;
        start_entry.timer = blink_on_ms;
      end
      mlbp_pkg::ACT_SHORT: begin
        cmd_start         = 1'b1;
        start_entry.phase = mlbp_pkg::PH_SHORT_ON;
        start_entry.timer = short_on_ms;
      end
      mlbp_pkg::ACT_LONG: begin
        cmd_start         = 1'b1;
        start_entry.phase = mlbp_pkg::PH_LONG_ON;
        start_entry.timer = long_on_ms;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tick update of one LED: count the timer down, and when it reaches zero in
  // a pattern phase, move to the other phase. Leaving an off phase without
  // auto-restart uses up one cycle; the last one ends the pattern dark.
  // ---------------------------------------------------------------------------
  logic [NUM_LEDS-1:0] drive, done;
  logic [15:0]         timer_dec;
  logic [15:0]         on_time, off_time;
  mlbp_pkg::phase_t    on_phase, off_phase;
  logic                go_on, go_off;
  logic [7:0]          cycles_dec;
  logic                wb_drive, wb_drive_set, wb_done_set;

  always_comb begin
    timer_dec    = rd_entry.timer - {15'd0, (rd_entry.timer != 16'd0)};
    wb_entry     = rd_entry;
    wb_entry.timer = timer_dec;
    cycles_dec   = rd_entry.cycles - 8'd1;
    go_on        = 1'b0;
    go_off       = 1'b0;
    on_time      = blink_on_ms;
    off_time     = blink_off_ms;
    on_phase     = mlbp_pkg::PH_BLINK_ON;
    off_phase    = mlbp_pkg::PH_BLINK_OFF;
    wb_drive     = 1'b0;
    wb_drive_set = 1'b0;
    wb_done_set  = 1'b0;

    case (rd_entry.phase)
      mlbp_pkg::PH_SHORT_ON, mlbp_pkg::PH_SHORT_OFF: begin
        on_time   = short_on_ms;
        off_time  = short_off_ms;
        on_phase  = mlbp_pkg::PH_SHORT_ON;
        off_phase = mlbp_pkg::PH_SHORT_OFF;
      end
      mlbp_pkg::PH_LONG_ON, mlbp_pkg::PH_LONG_OFF: begin
        on_time   = long_on_ms;
        off_time  = long_off_ms;
        on_phase  = mlbp_pkg::PH_LONG_ON;
        off_phase = mlbp_pkg::PH_LONG_OFF;
      end
      default: ;
    endcase

    if (timer_dec == 16'd0) begin
      case (rd_entry.phase)
        mlbp_pkg::PH_BLINK_ON, mlbp_pkg::PH_SHORT_ON, mlbp_pkg::PH_LONG_ON:
          go_off = 1'b1;
        mlbp_pkg::PH_BLINK_OFF, mlbp_pkg::PH_SHORT_OFF, mlbp_pkg::PH_LONG_OFF:
          go_on = 1'b1;
        default: ;
      endcase
    end

    if (go_off) begin
      wb_drive_set   = 1'b1;
      wb_drive       = 1'b0;
      wb_entry.timer = off_time;
      wb_entry.phase = off_phase;
    end else if (go_on) begin
      wb_drive_set = 1'b1;
      if (!rd_entry.restart) begin
        wb_entry.cycles = cycles_dec;
      end
      if (!rd_entry.restart && (cycles_dec == 8'd0)) begin
        wb_drive       = 1'b0;
        wb_entry.phase = mlbp_pkg::PH_DONE;
        wb_done_set    = 1'b1;
      end else begin
        wb_drive       = 1'b1;
        wb_entry.timer = on_time;
        wb_entry.phase = on_phase;
      end
    end
  end

  // The write port serves pattern starts while idle and write-back during a sweep.
  always_comb begin
    if (state == mlbp_pkg::S_TICK) begin
      wr_en    = wb_valid;
      wr_addr  = wb_idx;
      wr_entry = wb_entry;
    end else begin
      wr_en    = in_fire && cmd_hit && cmd_start;
      wr_addr  = cmd_idx;
      wr_entry = start_entry;
    end
  end

  // Drive levels and done flags live in flops so a result beat can read all
  // LEDs at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
      done  <= '0;
    end else if (in_fire && (act != mlbp_pkg::ACT_TICK) && cmd_hit) begin
      case (act)
        mlbp_pkg::ACT_ON:     drive[cmd_idx] <= 1'b1;
        mlbp_pkg::ACT_OFF:    drive[cmd_idx] <= 1'b0;
        mlbp_pkg::ACT_TOGGLE: drive[cmd_idx] <= ~drive[cmd_idx];
        mlbp_pkg::ACT_BLINK, mlbp_pkg::ACT_SHORT, mlbp_pkg::ACT_LONG: begin
          drive[cmd_idx] <= 1'b1;
          done[cmd_idx]  <= 1'b0;
        end
        default: ;
      endcase
    end else if ((state == mlbp_pkg::S_TICK) && wb_valid) begin
      if (wb_drive_set) begin
        drive[wb_idx] <= wb_drive;
      end
      if (wb_done_set) begin
        done[wb_idx] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. LEDs past the eighth are not reported; with fewer than
  // eight LEDs the upper bits read zero.
  // ---------------------------------------------------------------------------
  logic [NUM_LEDS+7:0] drive_pad, done_pad;

  assign drive_pad = {8'd0, drive};
  assign done_pad  = {8'd0, done};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      led_bits  <= drive_pad[7:0];
      done_bits <= done_pad[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The sweep never reads the entry that is being written back.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wb_valid) |-> (rd_addr != wb_idx))
    else $error("state memory read and write-back hit the same entry");

  // An accepted tick always starts a sweep.
  a_tick_sweeps: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (act == mlbp_pkg::ACT_TICK)) |=> (state == mlbp_pkg::S_TICK))
    else $error("tick accepted without starting a sweep");

  // Write-back happens only inside a sweep.
  a_wb_in_sweep: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> (state == mlbp_pkg::S_TICK))
    else $error("write-back outside of a sweep");

  // The read counter never runs past the LED count.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= CNT_END)
    else $error("sweep counter out of range");

  // A result beat is only loaded into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("result beat overwritten before it was taken");

endmodule

`default_nettype wire
